// File: rtl/bfa_pkg.sv
// Best-fit allocator package: request/response payload types and command codes.
// No dependencies; used by best_fit_allocator, bfa_ctrl and the testbench.
package bfa_pkg;

  localparam int SLOT_W  = 4;
  localparam int AMT_W   = 16;
  localparam int COUNT_W = 5;
  localparam int SLOT_SPAN = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [AMT_W-1:0]  amount;
  } req_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] chosen_slot;
    logic [AMT_W-1:0]  remaining;
  } rsp_t;

endpackage

// File: rtl/best_fit_allocator.sv
// Best-fit allocator top level: block_count register and the sequencer.
// Uses bfa_pkg, bfa_ctrl (which holds bfa_ram).
//
// Requests (req_valid/req_ready, payload req) are loads or allocations.
// A load writes one block's free size and gives no response.
// An allocation scans blocks 0..n-1, n = min(block_count, NUM_BLOCKS, 16),
// one RAM read per cycle, then writes back the chosen block. It takes no new
// request during the scan and write-back; the response (rsp_valid/rsp_ready,
// payload rsp) is registered in the write-back step.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls, a second allocation holds in its last step
// until the register frees.
// Reset clears control and sets block_count to 16; the free-size RAM is not
// cleared, so blocks must be loaded before they are allocated from.
// cfg_we/cfg_wdata write block_count; write only while idle.
module best_fit_allocator #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [bfa_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  bfa_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output bfa_pkg::rsp_t                rsp
);

  localparam int SPAN = (NUM_BLOCKS < bfa_pkg::SLOT_SPAN) ? NUM_BLOCKS : bfa_pkg::SLOT_SPAN;
  localparam int CW   = $clog2(SPAN + 1);

  logic [bfa_pkg::COUNT_W-1:0] block_count;
  logic [CW-1:0]               n;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bfa_pkg::COUNT_W'(16);
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  assign n = (32'(block_count) > 32'(SPAN)) ? CW'(SPAN) : CW'(block_count);

  bfa_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  a_nofit_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.granted |-> (rsp.chosen_slot == '0) && (rsp.remaining == '0))
    else $error("no-fit response carries nonzero fields");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.granted |-> (32'(rsp.chosen_slot) < 32'(SPAN)))
    else $error("granted slot outside scanned range");

  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.cmd == bfa_pkg::CMD_ALLOC) |=> !req_ready)
    else $error("request taken during allocation");

endmodule

// File: rtl/bfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bfa_ctrl.sv
// Best-fit allocator sequencer: loads, scans the free-size RAM one entry per
// cycle, writes back the chosen entry and holds the response register. Uses bfa_pkg, bfa_ram.
module bfa_ctrl #(
  parameter int NUM_BLOCKS = 16,
  parameter int CW = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [CW-1:0]  n,
  input  logic           req_valid,
  output logic           req_ready,
  input  bfa_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bfa_pkg::rsp_t  rsp
);

  localparam int AW = $clog2(NUM_BLOCKS);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FINISH
  } state_t;

  state_t                     state;
  logic [CW-1:0]              cnt_issue;
  logic [CW-1:0]              cnt_cmp;
  logic [bfa_pkg::AMT_W-1:0]  req_amt;
  logic                       found;
  logic [CW-1:0]              best_idx;
  logic [bfa_pkg::AMT_W-1:0]  best_val;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [bfa_pkg::AMT_W-1:0]  ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [bfa_pkg::AMT_W-1:0]  ram_rdata;

  logic                       accept;
  logic                       load_ok;
  logic [CW-1:0]              n_m1;
  logic                       better;
  logic                       emit;
  logic [bfa_pkg::AMT_W-1:0]  left;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;
  assign load_ok   = ({{(32-bfa_pkg::SLOT_W){1'b0}}, req.slot} < 32'(NUM_BLOCKS));
  assign n_m1      = n - CW'(1);
  assign better    = (ram_rdata >= req_amt) && (!found || (ram_rdata < best_val));
  assign emit      = (state == FINISH) && (!rsp_valid || rsp_ready);
  assign left      = best_val - req_amt;

  always_comb begin
    ram_raddr = (state == IDLE) ? '0 : AW'(cnt_issue);
    ram_we    = 1'b0;
    ram_waddr = AW'(req.slot);
    ram_wdata = req.amount;
    if (state == IDLE) begin
      ram_we = accept && (req.cmd == bfa_pkg::CMD_LOAD) && load_ok;
    end else if (emit) begin
      ram_we    = found;
      ram_waddr = AW'(best_idx);
      ram_wdata = left;
    end
  end

  bfa_ram #(
    .WIDTH (bfa_pkg::AMT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      cnt_issue <= '0;
      cnt_cmp   <= '0;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (req.cmd == bfa_pkg::CMD_ALLOC)) begin
            req_amt   <= req.amount;
            found     <= 1'b0;
            cnt_cmp   <= '0;
            cnt_issue <= CW'(n_m1 != '0);
            state     <= (n == '0) ? FINISH : SCAN;
          end
        end
        SCAN: begin
          if (better) begin
            found    <= 1'b1;
            best_idx <= cnt_cmp;
            best_val <= ram_rdata;
          end
          if (cnt_issue != n_m1) begin
            cnt_issue <= cnt_issue + CW'(1);
          end
          cnt_cmp <= cnt_cmp + CW'(1);
          if (cnt_cmp == n_m1) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (emit) begin
            rsp.granted     <= found;
            rsp.chosen_slot <= found ? bfa_pkg::SLOT_W'(best_idx) : '0;
            rsp.remaining   <= found ? left : '0;
            state           <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for best_fit_allocator: load and allocation requests with random
// idling on both handshakes, checked by a best-fit scoreboard class.
// Depends on bfa_pkg and the best_fit_allocator RTL.
module tb;

  localparam int NUM_BLOCKS = 16;
  localparam int SETTLE_CYCLES = NUM_BLOCKS + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 150;

  class alloc_ledger;
    logic [bfa_pkg::AMT_W-1:0]   free_size [NUM_BLOCKS];
    logic [bfa_pkg::COUNT_W-1:0] block_count;
    bfa_pkg::rsp_t               awaited_grants[$];
    int                          errors;
    int                          granted_cnt;
    int                          refused_cnt;

    function new();
      block_count = 5'd16;
      errors = 0;
      granted_cnt = 0;
      refused_cnt = 0;
    endfunction

    function void set_count(logic [bfa_pkg::COUNT_W-1:0] v);
      block_count = v;
    endfunction

    function void take_request(bfa_pkg::req_t r);
      int            n;
      int            best;
      bit            found;
      bfa_pkg::rsp_t res;
      if (r.cmd == bfa_pkg::CMD_LOAD) begin
        if (r.slot < NUM_BLOCKS) free_size[r.slot] = r.amount;
        return;
      end
      n = block_count;
      if (n > NUM_BLOCKS) n = NUM_BLOCKS;
      if (n > bfa_pkg::SLOT_SPAN) n = bfa_pkg::SLOT_SPAN;
      found = 1'b0;
      best = 0;
      for (int j = 0; j < n; j++) begin
        if (free_size[j] >= r.amount && (!found || free_size[best] > free_size[j])) begin
          best = j;
          found = 1'b1;
        end
      end
      res = '0;
      if (found) begin
        free_size[best] = free_size[best] - r.amount;
        res.granted = 1'b1;
        res.chosen_slot = best[bfa_pkg::SLOT_W-1:0];
        res.remaining = free_size[best];
        granted_cnt++;
      end else begin
        refused_cnt++;
      end
      awaited_grants.push_back(res);
    endfunction

    function void match_response(bfa_pkg::rsp_t got);
      bfa_pkg::rsp_t exp;
      if (awaited_grants.size() == 0) begin
        $display("%0t: unexpected response granted %0b slot %0d remaining %0d",
                 $time, got.granted, got.chosen_slot, got.remaining);
        errors++;
        return;
      end
      exp = awaited_grants.pop_front();
      if (got.granted !== exp.granted) begin
        $display("%0t: granted expected %0b actual %0b", $time, exp.granted, got.granted);
        errors++;
      end
      if (got.chosen_slot !== exp.chosen_slot) begin
        $display("%0t: chosen_slot expected %0d actual %0d",
                 $time, exp.chosen_slot, got.chosen_slot);
        errors++;
      end
      if (got.remaining !== exp.remaining) begin
        $display("%0t: remaining expected %0d actual %0d", $time, exp.remaining, got.remaining);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  bfa_pkg::req_t               req = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  bfa_pkg::rsp_t               rsp;

  alloc_ledger ledger;
  bit          no_idle = 1'b0;
  int          sent = 0;
  int          settings = 0;
  int          cycles = 0;
  int          preload [NUM_BLOCKS] = '{500, 65535, 0, 300, 300, 1, 1000, 1200,
                                        4096, 32768, 777, 2500, 60000, 123, 9999, 40000};
  int          probe [7] = '{0, 300, 65535, 65535, 1, 301, 2000};

  always #5 clk = ~clk;

  best_fit_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  function automatic bfa_pkg::req_t make_req(logic c, int s, int a);
    bfa_pkg::req_t r;
    r.cmd = c;
    r.slot = s[bfa_pkg::SLOT_W-1:0];
    r.amount = a[bfa_pkg::AMT_W-1:0];
    return r;
  endfunction

  function automatic bfa_pkg::req_t pick_request();
    bfa_pkg::req_t r;
    r.cmd = ($urandom_range(0, 9) < 3) ? bfa_pkg::CMD_LOAD : bfa_pkg::CMD_ALLOC;
    r.slot = bfa_pkg::SLOT_W'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0: r.amount = '0;
      1: r.amount = '1;
      2, 3: r.amount = bfa_pkg::AMT_W'($urandom_range(0, 65535));
      4, 5: r.amount = ledger.free_size[$urandom_range(0, NUM_BLOCKS - 1)];
      default: r.amount = bfa_pkg::AMT_W'($urandom_range(0, 1500));
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input bfa_pkg::req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    ledger.take_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_block_count(input logic [bfa_pkg::COUNT_W-1:0] v);
    req_valid <= 1'b0;
    while (ledger.awaited_grants.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    ledger.set_count(v);
    settings++;
  endtask

  initial begin
    logic [bfa_pkg::COUNT_W-1:0] plan [8];
    ledger = new();
    plan = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd16, 5'd2, 5'd2, 5'd16};
    plan[5] = bfa_pkg::COUNT_W'($urandom_range(2, 15));
    plan[6] = bfa_pkg::COUNT_W'($urandom_range(2, 15));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every block loaded before any allocation; includes ties and both extremes
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      send_request(make_req(bfa_pkg::CMD_LOAD, i, preload[i]));
    end
    foreach (probe[i]) send_request(make_req(bfa_pkg::CMD_ALLOC, 15 - i, probe[i]));

    foreach (plan[p]) begin
      write_block_count(plan[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        send_request(pick_request());
      end
    end

    req_valid <= 1'b0;
    while (ledger.awaited_grants.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d requests over %0d block-count settings (0, 1, 16, 17, 31 among them)",
             sent, settings + 1);
    $display("allocations: %0d granted, %0d refused", ledger.granted_cnt, ledger.refused_cnt);
    if (ledger.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      ledger.match_response(rsp);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

endmodule
